/* src/ubfp_pkg.sv */
// Package with the shared constants, command codes, status codes and state type.
package ubfp_pkg;

   // Ring sizes; each ring holds at most depth minus one bytes.
   localparam int RX_DEPTH = 64;
   localparam int TX_DEPTH = 64;
   localparam int RX_PTR_W = $clog2(RX_DEPTH);
   localparam int TX_PTR_W = $clog2(TX_DEPTH);

   // Field widths of a transaction.
   localparam int CMD_W    = 3;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 6;

   typedef enum logic [CMD_W-1:0] {
      CMD_RX_BYTE = 3'd0,
      CMD_READ    = 3'd1,
      CMD_WRITE   = 3'd2,
      CMD_TX_DONE = 3'd3,
      CMD_START   = 3'd4,
      CMD_STOP    = 3'd5,
      CMD_CLR_RX  = 3'd6,
      CMD_CLR_TX  = 3'd7
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_RX_EMPTY = 2'd1,
      STATUS_TX_FULL = 2'd2,
      STATUS_RX_FULL = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

endpackage

/* src/uart_buffered_fifo_pair_unit.sv */
// Top level of the UART receive and transmit ring buffer pair.
//
// This block keeps a receive ring and a transmit ring for a UART, plus the
// flag that says whether the transmitter is idle. A transaction is accepted
// at a clock edge where start is high and busy is low; it carries a command,
// a data byte and the transmitter's accept flag. When a transaction is
// accepted, the entries at both ring heads are read from the two ring
// memories into read registers; in the execute state the command is
// executed, the pointers and the idle flag are updated and at most one
// ring entry is written. Busy is high during that execute state only, so
// a new transaction is not accepted while the last one executes.
// The result of each transaction is shown on the rsp_ ports for exactly one
// cycle, marked by rsp_strobe, in the cycle right after execution; the
// receiver cannot hold it off, and a new transaction may be accepted in that
// same cycle. The ring memories are not cleared after reset, and none of
// their entries is used before a push has written it.
module uart_buffered_fifo_pair_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [ubfp_pkg::CMD_W-1:0]    req_cmd,
   input  logic [ubfp_pkg::BYTE_W-1:0]   req_data_byte,
   input  logic                          req_port_accepts,
   output logic                          rsp_strobe,
   output logic                          rsp_tx_send,
   output logic [ubfp_pkg::BYTE_W-1:0]   rsp_tx_byte,
   output logic [ubfp_pkg::BYTE_W-1:0]   rsp_rx_data,
   output logic [ubfp_pkg::STATUS_W-1:0] rsp_status,
   output logic [ubfp_pkg::COUNT_W-1:0]  rsp_rx_count,
   output logic [ubfp_pkg::COUNT_W-1:0]  rsp_tx_count,
   output logic                          rsp_port_idle
);

   localparam int RXW = ubfp_pkg::RX_PTR_W;
   localparam int TXW = ubfp_pkg::TX_PTR_W;

   // Advance a ring pointer with wrap at the ring depth.
   function automatic logic [RXW-1:0] rx_next(input logic [RXW-1:0] ptr);
      return (ptr == RXW'(ubfp_pkg::RX_DEPTH - 1)) ? '0 : ptr + RXW'(1);
   endfunction

   function automatic logic [TXW-1:0] tx_next(input logic [TXW-1:0] ptr);
      return (ptr == TXW'(ubfp_pkg::TX_DEPTH - 1)) ? '0 : ptr + TXW'(1);
   endfunction

   // Ring memories; read at accept, written during execution.
   logic [ubfp_pkg::BYTE_W-1:0] rx_mem [ubfp_pkg::RX_DEPTH];
   logic [ubfp_pkg::BYTE_W-1:0] tx_mem [ubfp_pkg::TX_DEPTH];
   logic [ubfp_pkg::BYTE_W-1:0] rx_rd_ff;
   logic [ubfp_pkg::BYTE_W-1:0] tx_rd_ff;

   ubfp_pkg::state_type state_ff, state_in;
   logic                accept;

   // Latched transaction.
   ubfp_pkg::cmd_type           cmd_ff;
   logic [ubfp_pkg::BYTE_W-1:0] data_ff;
   logic                        acc_ff;

   // Ring pointers and the idle flag.
   logic [RXW-1:0] rx_head_ff, rx_head_in, rx_tail_ff, rx_tail_in;
   logic [TXW-1:0] tx_head_ff, tx_head_in, tx_tail_ff, tx_tail_in;
   logic           idle_ff, idle_in;
   logic [RXW-1:0] rx_nt;
   logic [TXW-1:0] tx_nt;

   // Execute-cycle results.
   logic                        rx_we, tx_we;
   logic                        send_in;
   logic [ubfp_pkg::BYTE_W-1:0] txb_in, rxd_in;
   ubfp_pkg::status_type        status_in;
   logic [RXW:0]                rx_cnt_full;
   logic [TXW:0]                tx_cnt_full;

   // Result registers.
   logic                          strobe_ff;
   logic                          send_ff;
   logic [ubfp_pkg::BYTE_W-1:0]   txb_ff, rxd_ff;
   logic [ubfp_pkg::STATUS_W-1:0] status_ff;
   logic [ubfp_pkg::COUNT_W-1:0]  rx_cnt_ff, tx_cnt_ff;
   logic                          idle_out_ff;

   assign accept = start && !busy;

   // Next-state logic: an execute state after every accepted transaction.
   always_comb begin
      unique case (state_ff)
         ubfp_pkg::ST_IDLE: state_in = accept ? ubfp_pkg::ST_EXEC : ubfp_pkg::ST_IDLE;
         ubfp_pkg::ST_EXEC: state_in = ubfp_pkg::ST_IDLE;
         default:           state_in = ubfp_pkg::ST_IDLE;
      endcase
   end

   // Output logic of the state machine.
   always_comb begin
      unique case (state_ff)
         ubfp_pkg::ST_IDLE: busy = 1'b0;
         ubfp_pkg::ST_EXEC: busy = 1'b1;
         default:           busy = 1'b0;
      endcase
   end

   // Command execution on the head entries read at the accept edge.
   always_comb begin
      rx_head_in = rx_head_ff;
      rx_tail_in = rx_tail_ff;
      tx_head_in = tx_head_ff;
      tx_tail_in = tx_tail_ff;
      idle_in    = idle_ff;
      rx_we      = 1'b0;
      tx_we      = 1'b0;
      send_in    = 1'b0;
      txb_in     = '0;
      rxd_in     = '0;
      status_in  = ubfp_pkg::STATUS_OK;
      rx_nt      = rx_next(rx_tail_ff);
      tx_nt      = tx_next(tx_tail_ff);
      unique case (cmd_ff)
         ubfp_pkg::CMD_RX_BYTE: begin
            // A full ring drops its oldest byte to make room.
            rx_we      = 1'b1;
            rx_tail_in = rx_nt;
            if (rx_nt == rx_head_ff) begin
               rx_head_in = rx_next(rx_head_ff);
               status_in  = ubfp_pkg::STATUS_RX_FULL;
            end
         end
         ubfp_pkg::CMD_READ: begin
            if (rx_head_ff == rx_tail_ff) begin
               status_in = ubfp_pkg::STATUS_RX_EMPTY;
            end else begin
               rxd_in     = rx_rd_ff;
               rx_head_in = rx_next(rx_head_ff);
            end
         end
         ubfp_pkg::CMD_WRITE: begin
            if (idle_ff && acc_ff) begin
               send_in = 1'b1;
               txb_in  = data_ff;
               idle_in = 1'b0;
            end else if (tx_nt == tx_head_ff) begin
               status_in = ubfp_pkg::STATUS_TX_FULL;
            end else begin
               tx_we      = 1'b1;
               tx_tail_in = tx_nt;
            end
         end
         ubfp_pkg::CMD_TX_DONE: begin
            if (tx_head_ff != tx_tail_ff && acc_ff) begin
               send_in    = 1'b1;
               txb_in     = tx_rd_ff;
               tx_head_in = tx_next(tx_head_ff);
            end else begin
               idle_in = 1'b1;
            end
         end
         ubfp_pkg::CMD_START: begin
            // With bytes queued, a refusing port leaves the idle flag alone.
            if (tx_head_ff != tx_tail_ff) begin
               if (acc_ff) begin
                  send_in    = 1'b1;
                  txb_in     = tx_rd_ff;
                  tx_head_in = tx_next(tx_head_ff);
               end
            end else begin
               idle_in = 1'b1;
            end
         end
         ubfp_pkg::CMD_STOP: begin
            idle_in = 1'b0;
         end
         ubfp_pkg::CMD_CLR_RX: begin
            rx_head_in = '0;
            rx_tail_in = '0;
         end
         ubfp_pkg::CMD_CLR_TX: begin
            tx_head_in = '0;
            tx_tail_in = '0;
         end
         default: begin
            status_in = ubfp_pkg::STATUS_OK;
         end
      endcase
   end

   // Fill levels after the update.
   always_comb begin
      if (rx_tail_in >= rx_head_in) begin
         rx_cnt_full = {1'b0, rx_tail_in} - {1'b0, rx_head_in};
      end else begin
         rx_cnt_full = (RXW+1)'(ubfp_pkg::RX_DEPTH) - {1'b0, rx_head_in} + {1'b0, rx_tail_in};
      end
      if (tx_tail_in >= tx_head_in) begin
         tx_cnt_full = {1'b0, tx_tail_in} - {1'b0, tx_head_in};
      end else begin
         tx_cnt_full = (TXW+1)'(ubfp_pkg::TX_DEPTH) - {1'b0, tx_head_in} + {1'b0, tx_tail_in};
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ubfp_pkg::ST_IDLE;
         rx_head_ff <= '0;
         rx_tail_ff <= '0;
         tx_head_ff <= '0;
         tx_tail_ff <= '0;
         idle_ff    <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= (state_ff == ubfp_pkg::ST_EXEC);
         if (state_ff == ubfp_pkg::ST_EXEC) begin
            rx_head_ff <= rx_head_in;
            rx_tail_ff <= rx_tail_in;
            tx_head_ff <= tx_head_in;
            tx_tail_ff <= tx_tail_in;
            idle_ff    <= idle_in;
         end
      end
   end

   // Transaction latch and result registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= ubfp_pkg::cmd_type'(req_cmd);
         data_ff <= req_data_byte;
         acc_ff  <= req_port_accepts;
      end
      if (state_ff == ubfp_pkg::ST_EXEC) begin
         send_ff     <= send_in;
         txb_ff      <= txb_in;
         rxd_ff      <= rxd_in;
         status_ff   <= status_in;
         rx_cnt_ff   <= ubfp_pkg::COUNT_W'(rx_cnt_full);
         tx_cnt_ff   <= ubfp_pkg::COUNT_W'(tx_cnt_full);
         idle_out_ff <= idle_in;
      end
   end

   // Ring memories: head reads at accept, tail writes at execution.
   always_ff @(posedge clock) begin
      if (accept) begin
         rx_rd_ff <= rx_mem[rx_head_ff];
         tx_rd_ff <= tx_mem[tx_head_ff];
      end
      if (state_ff == ubfp_pkg::ST_EXEC && rx_we) begin
         rx_mem[rx_tail_ff] <= data_ff;
      end
      if (state_ff == ubfp_pkg::ST_EXEC && tx_we) begin
         tx_mem[tx_tail_ff] <= data_ff;
      end
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_tx_send   = send_ff;
   assign rsp_tx_byte   = txb_ff;
   assign rsp_rx_data   = rxd_ff;
   assign rsp_status    = status_ff;
   assign rsp_rx_count  = rx_cnt_ff;
   assign rsp_tx_count  = tx_cnt_ff;
   assign rsp_port_idle = idle_out_ff;

endmodule

/* src/ubfp_checker.sv */
// Port-level checker for the ring buffer pair, with its bind statement.
module ubfp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_strobe,
   input logic                          rsp_tx_send,
   input logic [ubfp_pkg::BYTE_W-1:0]   rsp_tx_byte,
   input logic [ubfp_pkg::BYTE_W-1:0]   rsp_rx_data,
   input logic [ubfp_pkg::STATUS_W-1:0] rsp_status
);

   // An accepted transaction executes in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_strobe)
      else $error("accepted transaction did not enter execution");

   // Execution lasts one cycle and its result follows right after.
   assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_strobe && !busy)
      else $error("result strobe missing after execution");

   // A result never coincides with execution.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   // No byte is shown to the transmitter unless one is sent.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_tx_send |-> rsp_tx_byte == '0)
      else $error("transmit byte nonzero without a send");

   // A read of an empty ring returns zero data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == ubfp_pkg::STATUS_RX_EMPTY |-> rsp_rx_data == '0)
      else $error("empty read returned data");

endmodule

bind uart_buffered_fifo_pair_unit ubfp_checker u_ubfp_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_strobe  (rsp_strobe),
   .rsp_tx_send (rsp_tx_send),
   .rsp_tx_byte (rsp_tx_byte),
   .rsp_rx_data (rsp_rx_data),
   .rsp_status  (rsp_status)
);

/* sim/tb.sv */
// Testbench for the UART receive and transmit ring buffer pair, with its own predictor.
module tb;
   import ubfp_pkg::*;

   // One result transaction as the block presents it on the rsp_ ports.
   typedef struct packed {
      logic               tx_send;
      logic [BYTE_W-1:0]  tx_byte;
      logic [BYTE_W-1:0]  rx_data;
      status_type         status;
      logic [COUNT_W-1:0] rx_count;
      logic [COUNT_W-1:0] tx_count;
      logic               port_idle;
   } uart_resp_t;

   // One row of the directed table. When typed is set, the row carries its own
   // expected result; otherwise the predictor supplies it.
   typedef struct packed {
      cmd_type           cmd;
      logic [BYTE_W-1:0] data;
      logic              accepts;
      logic              typed;
      uart_resp_t        exp;
   } dir_row_t;

   // Traffic mixes for the random part: one that fills both rings, one that
   // drains them, and one that spreads nearly evenly over all commands.
   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_kind;

   localparam int RANDOM_ITEMS = 1700;
   localparam int NUM_DIRECTED = 22;
   localparam int DRAIN_LIMIT  = 1000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [CMD_W-1:0]    req_cmd = '0;
   logic [BYTE_W-1:0]   req_data_byte = '0;
   logic                req_port_accepts = 1'b0;
   logic                rsp_strobe;
   logic                rsp_tx_send;
   logic [BYTE_W-1:0]   rsp_tx_byte;
   logic [BYTE_W-1:0]   rsp_rx_data;
   logic [STATUS_W-1:0] rsp_status;
   logic [COUNT_W-1:0]  rsp_rx_count;
   logic [COUNT_W-1:0]  rsp_tx_count;
   logic                rsp_port_idle;

   // Typed expectation that travels alongside the driven transaction, so the
   // monitor can pick it up at the edge where the transaction is accepted.
   logic       row_typed = 1'b0;
   uart_resp_t row_exp = '0;

   // Predictor state: both rings, their indices and the port idle flag.
   logic [BYTE_W-1:0] rx_ring [RX_DEPTH];
   logic [BYTE_W-1:0] tx_ring [TX_DEPTH];
   int                rx_head = 0;
   int                rx_tail = 0;
   int                tx_head = 0;
   int                tx_tail = 0;
   logic              tx_idle = 1'b0;

   uart_resp_t pending_resps [$];
   int         mismatch_count = 0;
   logic       gaps_on = 1'b1;

   // Percent weights per mix, in command-code order: rx byte, read, write,
   // transmit done, start, stop, clear rx, clear tx. Clears stay rare in the
   // fill mix so that both rings actually reach their full state.
   int mix_weight [3][8] = '{
      '{45,  3, 40,  3,  2,  5,  1,  1},
      '{ 5, 40,  5, 35,  6,  5,  2,  2},
      '{13, 13, 13, 13, 12, 12, 12, 12}
   };

   // The directed table covers the special cases one at a time: reads of an
   // empty ring, receives before start, a refused port on transmit done and on
   // start, direct sends, start with an empty queue, stop and both clears.
   dir_row_t directed_rows [NUM_DIRECTED] = '{
      '{CMD_READ,    8'h00, 1'b0, 1'b1,
        '{1'b0, 8'h00, 8'h00, STATUS_RX_EMPTY, 6'd0, 6'd0, 1'b0}},
      '{CMD_RX_BYTE, 8'h00, 1'b0, 1'b0, '0},
      '{CMD_RX_BYTE, 8'hFF, 1'b1, 1'b0, '0},
      '{CMD_READ,    8'hFF, 1'b0, 1'b0, '0},
      '{CMD_READ,    8'h00, 1'b1, 1'b0, '0},
      '{CMD_READ,    8'h00, 1'b0, 1'b1,
        '{1'b0, 8'h00, 8'h00, STATUS_RX_EMPTY, 6'd0, 6'd0, 1'b0}},
      '{CMD_WRITE,   8'hA5, 1'b1, 1'b0, '0},
      '{CMD_TX_DONE, 8'h00, 1'b0, 1'b0, '0},
      '{CMD_START,   8'hFF, 1'b0, 1'b0, '0},
      '{CMD_TX_DONE, 8'h00, 1'b1, 1'b0, '0},
      '{CMD_TX_DONE, 8'h00, 1'b1, 1'b0, '0},
      '{CMD_WRITE,   8'hFF, 1'b1, 1'b0, '0},
      '{CMD_START,   8'h00, 1'b1, 1'b0, '0},
      '{CMD_WRITE,   8'h00, 1'b0, 1'b0, '0},
      '{CMD_WRITE,   8'h5A, 1'b1, 1'b0, '0},
      '{CMD_STOP,    8'hFF, 1'b1, 1'b0, '0},
      '{CMD_START,   8'h00, 1'b1, 1'b0, '0},
      '{CMD_WRITE,   8'h3C, 1'b0, 1'b0, '0},
      '{CMD_CLR_TX,  8'h00, 1'b0, 1'b1,
        '{1'b0, 8'h00, 8'h00, STATUS_OK, 6'd0, 6'd0, 1'b0}},
      '{CMD_RX_BYTE, 8'h81, 1'b0, 1'b0, '0},
      '{CMD_CLR_RX,  8'h00, 1'b0, 1'b1,
        '{1'b0, 8'h00, 8'h00, STATUS_OK, 6'd0, 6'd0, 1'b0}},
      '{CMD_CLR_TX,  8'hFF, 1'b1, 1'b0, '0}
   };

   uart_buffered_fifo_pair_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_data_byte    (req_data_byte),
      .req_port_accepts (req_port_accepts),
      .rsp_strobe       (rsp_strobe),
      .rsp_tx_send      (rsp_tx_send),
      .rsp_tx_byte      (rsp_tx_byte),
      .rsp_rx_data      (rsp_rx_data),
      .rsp_status       (rsp_status),
      .rsp_rx_count     (rsp_rx_count),
      .rsp_tx_count     (rsp_tx_count),
      .rsp_port_idle    (rsp_port_idle)
   );

   always #5 clock = ~clock;

   function automatic int ring_advance(int idx, int depth);
      return (idx + 1 >= depth) ? 0 : idx + 1;
   endfunction

   function automatic int ring_fill(int head, int tail, int depth);
      return (tail >= head) ? tail - head : depth - head + tail;
   endfunction

   // Hands the oldest queued byte to the transmitter.
   function automatic void send_from_queue(ref uart_resp_t r);
      r.tx_send = 1'b1;
      r.tx_byte = tx_ring[tx_head];
      tx_head = ring_advance(tx_head, TX_DEPTH);
   endfunction

   // Applies one command to the predictor state and returns its result.
   function automatic uart_resp_t uart_pair_step(cmd_type c, logic [BYTE_W-1:0] d,
                                                 logic acc);
      uart_resp_t r;
      int         next_tail;
      r = '0;
      r.status = STATUS_OK;
      case (c)
         CMD_RX_BYTE: begin
            // A full receive ring keeps the new byte and loses the oldest.
            rx_ring[rx_tail] = d;
            rx_tail = ring_advance(rx_tail, RX_DEPTH);
            if (rx_tail == rx_head) begin
               rx_head = ring_advance(rx_head, RX_DEPTH);
               r.status = STATUS_RX_FULL;
            end
         end
         CMD_READ: begin
            if (rx_head == rx_tail) begin
               r.status = STATUS_RX_EMPTY;
            end else begin
               r.rx_data = rx_ring[rx_head];
               rx_head = ring_advance(rx_head, RX_DEPTH);
            end
         end
         CMD_WRITE: begin
            if (tx_idle && acc) begin
               r.tx_send = 1'b1;
               r.tx_byte = d;
               tx_idle = 1'b0;
            end else begin
               // A full transmit ring drops the newest byte.
               next_tail = ring_advance(tx_tail, TX_DEPTH);
               if (next_tail == tx_head) begin
                  r.status = STATUS_TX_FULL;
               end else begin
                  tx_ring[tx_tail] = d;
                  tx_tail = next_tail;
               end
            end
         end
         CMD_TX_DONE: begin
            if (tx_head != tx_tail && acc) begin
               send_from_queue(r);
            end else begin
               tx_idle = 1'b1;
            end
         end
         CMD_START: begin
            if (tx_head != tx_tail) begin
               if (acc) begin
                  send_from_queue(r);
               end
            end else begin
               tx_idle = 1'b1;
            end
         end
         CMD_STOP: begin
            tx_idle = 1'b0;
         end
         CMD_CLR_RX: begin
            rx_head = 0;
            rx_tail = 0;
         end
         default: begin
            tx_head = 0;
            tx_tail = 0;
         end
      endcase
      r.rx_count = COUNT_W'(ring_fill(rx_head, rx_tail, RX_DEPTH));
      r.tx_count = COUNT_W'(ring_fill(tx_head, tx_tail, TX_DEPTH));
      r.port_idle = tx_idle;
      return r;
   endfunction

   function automatic cmd_type pick_cmd(mix_kind mix);
      int roll;
      int acc;
      roll = $urandom_range(0, 99);
      acc = 0;
      for (int k = 0; k < 8; k++) begin
         acc += mix_weight[mix][k];
         if (roll < acc) return cmd_type'(k);
      end
      return CMD_CLR_TX;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Drives one transaction. Called just after a falling edge and returns just
   // after the falling edge that follows its acceptance. Random idle cycles
   // with start low come first, unless gaps are switched off.
   task automatic drive_event(cmd_type c, logic [BYTE_W-1:0] d, logic acc,
                              logic typed, uart_resp_t exp);
      while (gaps_on && $urandom_range(0, 99) < 8) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start            <= 1'b1;
      req_cmd          <= c;
      req_data_byte    <= d;
      req_port_accepts <= acc;
      row_typed        <= typed;
      row_exp          <= exp;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   // Monitor: at every rising edge, first check a result that is on the ports,
   // then predict the result of a transaction that is accepted at this edge.
   // A result can never belong to the transaction accepted at the same edge,
   // so this order is safe.
   always @(posedge clock) begin
      uart_resp_t want;
      uart_resp_t predicted;
      if (!reset) begin
         if (rsp_strobe) begin
            if (pending_resps.size() == 0) begin
               report_mismatch("result with nothing expected", 0, 0);
            end else begin
               want = pending_resps.pop_front();
               if (rsp_tx_send !== want.tx_send)
                  report_mismatch("tx_send", rsp_tx_send, want.tx_send);
               if (rsp_tx_byte !== want.tx_byte)
                  report_mismatch("tx_byte", rsp_tx_byte, want.tx_byte);
               if (rsp_rx_data !== want.rx_data)
                  report_mismatch("rx_data", rsp_rx_data, want.rx_data);
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_rx_count !== want.rx_count)
                  report_mismatch("rx_count", rsp_rx_count, want.rx_count);
               if (rsp_tx_count !== want.tx_count)
                  report_mismatch("tx_count", rsp_tx_count, want.tx_count);
               if (rsp_port_idle !== want.port_idle)
                  report_mismatch("port_idle", rsp_port_idle, want.port_idle);
            end
         end
         if (start && !busy) begin
            // The predictor always advances, so a typed row stays in step with
            // the state for the rows that follow it.
            predicted = uart_pair_step(cmd_type'(req_cmd), req_data_byte, req_port_accepts);
            pending_resps.push_back(row_typed ? row_exp : predicted);
         end
      end
   end

   // Stimulus: reset, the directed table, the random part, then the drain.
   initial begin
      mix_kind mix;
      int      mix_left;
      int      waited;
      mix = MIX_EVEN;
      mix_left = 0;
      waited = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         drive_event(directed_rows[i].cmd, directed_rows[i].data,
                     directed_rows[i].accepts, directed_rows[i].typed,
                     directed_rows[i].exp);
      end

      // Random traffic runs in stretches of one mix each, of 100 to 250
      // transactions. A block of transactions in the middle runs back to back
      // with no idle cycles.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (mix_left == 0) begin
            mix = mix_kind'($urandom_range(0, 2));
            mix_left = $urandom_range(100, 250);
         end
         mix_left--;
         gaps_on = !(i >= 500 && i < 900);
         drive_event(pick_cmd(mix), BYTE_W'($urandom_range(0, 255)),
                     (mix == MIX_DRAIN) ? ($urandom_range(0, 99) < 85)
                                        : 1'($urandom_range(0, 1)),
                     1'b0, '0);
      end
      start <= 1'b0;

      // Wait for the last results, then keep watching for strays before the final check.
      while (pending_resps.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
      while (pending_resps.size() != 0) begin
         void'(pending_resps.pop_front());
         report_mismatch("result never arrived", 0, 0);
      end

      if (mismatch_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run of this stimulus.
   initial begin
      #5000000;
      $display("tb: errors");
      $finish;
   end

endmodule
